[src/swrbg_pkg.sv]
// ----------------------------------------------------------------------------
// swrbg_pkg
// Shared widths, constants, result types and LED pattern tables for the
// SWR bargraph driver.
// ----------------------------------------------------------------------------
package swrbg_pkg;

  localparam int LEVEL_W    = 15;
  localparam int SUM_W      = LEVEL_W + 1;
  localparam int DIVIDEND_W = SUM_W + 1;
  localparam int DIVISOR_W  = LEVEL_W;
  localparam int STEP_W     = $clog2(DIVIDEND_W);
  localparam int RATIO_W    = 8;

  localparam logic [2:0]         NORM_MAX    = 3'd5;
  localparam logic [RATIO_W-1:0] RATIO_SAT   = 8'd255;
  localparam logic [2:0]         LED_LAST    = 3'd6;

  // segment boundaries of the ratio -> LED mapping
  localparam logic [RATIO_W-1:0] SEG2_START  = 8'd48;
  localparam logic [RATIO_W-1:0] SEG3_START  = 8'd64;
  localparam logic [RATIO_W-1:0] SEG4_START  = 8'd96;
  localparam logic [RATIO_W-1:0] SEG5_START  = 8'd160;
  localparam logic [9:0]         SEG5_SCALE  = 10'd683;
  localparam logic [16:0]        SEG5_ROUND  = 17'd127;

  localparam logic [7:0]         FRAC_HALF   = 8'd128;
  localparam logic [7:0]         TC_BIAS     = 8'd32;
  localparam logic [7:0]         TC_FULL     = 8'd192;
  localparam logic [7:0]         TC_CLAMP    = 8'd236;

  // charlieplex pins
  localparam logic [4:0] PIN_A = 5'h10;
  localparam logic [4:0] PIN_B = 5'h01;
  localparam logic [4:0] PIN_C = 5'h02;

  typedef struct packed {
    logic [2:0] led_index;
    logic [7:0] led_fraction;
    logic [4:0] first_dir;
    logic [4:0] first_out;
    logic [4:0] second_dir;
    logic [4:0] second_out;
    logic [7:0] timer_compare;
  } map_res_t;

  function automatic logic [4:0] pat_dir(input logic [2:0] pos);
    logic [4:0] d;
    unique case (pos) inside
      3'd0:         d = PIN_A | PIN_B | PIN_C;
      3'd1, 3'd2:   d = PIN_A | PIN_B;
      3'd3, 3'd4:   d = PIN_A | PIN_C;
      default:      d = PIN_B | PIN_C;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] pat_out(input logic [2:0] pos);
    logic [4:0] o;
    unique case (pos) inside
      3'd0:         o = 5'h00;
      3'd1:         o = PIN_B;
      3'd2, 3'd3:   o = PIN_A;
      3'd4, 3'd5:   o = PIN_C;
      default:      o = PIN_B;
    endcase
    return o;
  endfunction

endpackage

[src/swrbg_div.sv]
// ----------------------------------------------------------------------------
// swrbg_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swrbg_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start_i,
  input  logic [swrbg_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic [swrbg_pkg::DIVISOR_W-1:0]   divisor_i,
  output logic [swrbg_pkg::DIVIDEND_W-1:0]  quotient_o,
  output logic                              done_o
);
  import swrbg_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIVIDEND_W - 1);

  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [STEP_W-1:0]     cnt_r;
  logic                  run_r;
  logic                  done_r;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  take;

  always_comb begin
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs_r};
    take  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: load operands, then shift one quotient bit in per step
  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      dvs_r <= divisor_i;
    end else if (run_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], take};
      rem_r <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient_o = quo_r;
  assign done_o     = done_r;

endmodule

[src/swrbg_map.sv]
// ----------------------------------------------------------------------------
// swrbg_map
// Maps an SWR ratio to LED index, fraction, pin patterns and compare value.
// ----------------------------------------------------------------------------
module swrbg_map (
  input  logic                            valid_i,
  input  logic [swrbg_pkg::RATIO_W-1:0]   ratio_i,
  output swrbg_pkg::map_res_t             res_o
);
  import swrbg_pkg::*;

  logic [2:0]  idx;
  logic [2:0]  idx_next;
  logic [7:0]  frac;
  logic [7:0]  off4;
  logic [6:0]  off5;
  logic [16:0] prod5;
  logic [7:0]  t;
  logic [7:0]  t_bias;
  logic [7:0]  tc;
  logic        swap;
  logic [4:0]  d_lo, o_lo, d_hi, o_hi;

  always_comb begin
    off4  = ratio_i - SEG4_START;
    off5  = 7'(ratio_i - SEG5_START);
    prod5 = ({10'b0, off5} * {7'b0, SEG5_SCALE}) + SEG5_ROUND;
    if (!valid_i) begin
      idx  = LED_LAST;
      frac = '0;
    end else if (ratio_i < SEG3_START) begin
      idx  = (ratio_i < SEG2_START) ? 3'd1 : 3'd2;
      frac = {ratio_i[3:0], 4'b0};
    end else if (ratio_i < SEG4_START) begin
      idx  = 3'd3;
      frac = {ratio_i[4:0], 3'b0};
    end else if (ratio_i < SEG5_START) begin
      idx  = 3'd4;
      frac = {off4[5:0], 2'b0};
    end else begin
      idx  = 3'd5;
      frac = prod5[15:8];
    end

    idx_next = idx + 3'd1;
    d_lo = pat_dir(idx);
    o_lo = pat_out(idx);
    d_hi = pat_dir(idx_next);
    o_hi = pat_out(idx_next);

    // upper half of the fraction: swap the patterns so the longer part leads
    swap   = (frac >= FRAC_HALF);
    t      = swap ? frac : (8'hFF - frac);
    t_bias = t + TC_BIAS;
    tc     = {t_bias[7:6], 6'b0};
    if (tc == TC_FULL) begin
      tc = TC_CLAMP;
    end

    res_o.led_index     = idx;
    res_o.led_fraction  = frac;
    res_o.first_dir     = swap ? d_hi : d_lo;
    res_o.first_out     = swap ? o_hi : o_lo;
    res_o.second_dir    = swap ? d_lo : d_hi;
    res_o.second_out    = swap ? o_lo : o_hi;
    res_o.timer_compare = tc;
  end

endmodule

[src/swr_bargraph_driver_core.sv]
// ----------------------------------------------------------------------------
// swr_bargraph_driver_core
// SWR = (F+R)/(F-R) with 5 fraction bits, mapped to a charlieplexed bargraph.
// Path: when F > R and the shifted difference is nonzero, a request runs the
//   17 divider steps, then capture and mapping; else straight to mapping.
// A new request waits until the previous one is through, so the 17-step
//   restoring divider dominates on the divide path; busy is high meanwhile.
// Results show for one cycle under out_strobe; the receiver cannot stall.
// Reset (rst_n low, synchronous) idles the sequencer and drops out_strobe.
// ----------------------------------------------------------------------------
module swr_bargraph_driver_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [swrbg_pkg::LEVEL_W-1:0]   in_forward_level,
  input  logic [swrbg_pkg::LEVEL_W-1:0]   in_reflected_level,
  output logic                            out_strobe,
  output logic                            out_swr_valid,
  output logic [7:0]                      out_swr_ratio,
  output logic [2:0]                      out_led_index,
  output logic [7:0]                      out_led_fraction,
  output logic [4:0]                      out_first_dir,
  output logic [4:0]                      out_first_out,
  output logic [4:0]                      out_second_dir,
  output logic [4:0]                      out_second_out,
  output logic [7:0]                      out_timer_compare
);
  import swrbg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_MAP  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   valid_r, valid_nxt;
  logic [RATIO_W-1:0]     ratio_r, ratio_nxt;

  logic                   accept;
  logic                   fwd_gt;
  logic [SUM_W-1:0]       sum_w;
  logic [LEVEL_W-1:0]     diff_w;
  logic [2:0]             sh;
  logic [SUM_W-1:0]       top_n;
  logic [DIVISOR_W-1:0]   bot_s;
  logic [DIVIDEND_W-1:0]  dividend;
  logic                   div_start;
  logic [DIVIDEND_W-1:0]  div_quo;
  logic                   div_done;
  logic [RATIO_W-1:0]     quo_sat;
  map_res_t               map_res;

  // Request handshake: take a new pair whenever the sequencer is idle.
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Normalize the sum: shift left until one of its top two bits is set,
  // at most five places. The difference drops the shifts left unused.
  always_comb begin
    fwd_gt = (in_forward_level > in_reflected_level);
    sum_w  = {1'b0, in_forward_level} + {1'b0, in_reflected_level};
    diff_w = in_forward_level - in_reflected_level;
    if (sum_w[15:14] != 2'b00) begin
      sh = 3'd0;
    end else if (sum_w[13]) begin
      sh = 3'd1;
    end else if (sum_w[12]) begin
      sh = 3'd2;
    end else if (sum_w[11]) begin
      sh = 3'd3;
    end else if (sum_w[10]) begin
      sh = 3'd4;
    end else begin
      sh = NORM_MAX;
    end
    top_n    = sum_w << sh;
    bot_s    = diff_w >> (NORM_MAX - sh);
    // add half the divisor so the truncating divide rounds to nearest
    dividend = {1'b0, top_n} + {2'b0, bot_s[DIVISOR_W-1:1]};
  end

  // A zero divisor skips the divider and saturates the ratio directly.
  assign div_start = accept && fwd_gt && (bot_s != '0);

  swrbg_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (bot_s),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  // Saturate the quotient to eight bits.
  assign quo_sat = (div_quo[DIVIDEND_W-1:RATIO_W] != '0) ? RATIO_SAT : div_quo[RATIO_W-1:0];

  // Sequencer: idle -> divide -> map, or straight to map on the short path.
  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    ratio_nxt = ratio_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          valid_nxt = fwd_gt;
          ratio_nxt = RATIO_SAT;
          state_nxt = div_start ? S_DIV : S_MAP;
        end
      end
      S_DIV: begin
        if (div_done) begin
          ratio_nxt = quo_sat;
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    valid_r <= valid_nxt;
    ratio_r <= ratio_nxt;
  end

  // LED index, fraction, patterns and compare value from the held ratio.
  swrbg_map u_map (
    .valid_i (valid_r),
    .ratio_i (ratio_r),
    .res_o   (map_res)
  );

  // Output register: load in the map cycle, flag under out_strobe for exactly one cycle.
  logic                 strobe_r;
  logic                 o_valid_r;
  logic [RATIO_W-1:0]   o_ratio_r;
  map_res_t             o_map_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (state_r == S_MAP);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MAP) begin
      o_valid_r <= valid_r;
      o_ratio_r <= ratio_r;
      o_map_r   <= map_res;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_swr_valid     = o_valid_r;
  assign out_swr_ratio     = o_ratio_r;
  assign out_led_index     = o_map_r.led_index;
  assign out_led_fraction  = o_map_r.led_fraction;
  assign out_first_dir     = o_map_r.first_dir;
  assign out_first_out     = o_map_r.first_out;
  assign out_second_dir    = o_map_r.second_dir;
  assign out_second_out    = o_map_r.second_out;
  assign out_timer_compare = o_map_r.timer_compare;

  // A result only follows the map cycle.
  a_strobe_after_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_MAP))
    else $error("result strobe without map cycle");

  // An accepted request keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  // Forward not above reflected shows the last LED at full scale.
  a_invalid_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_swr_valid) |->
      (out_swr_ratio == RATIO_SAT && out_led_index == LED_LAST && out_led_fraction == 8'd0))
    else $error("invalid result not at last LED");

  // A computed SWR always lands on LED 1 to 5.
  a_valid_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_swr_valid) |->
      (out_led_index >= 3'd1 && out_led_index <= 3'd5))
    else $error("computed SWR outside LED range");

endmodule
